### hdl/cnc_arc_length_unit_defines.svh
// Assertion macros used by the port-level checker of the arc length unit.
// Depends on nothing; include by bare file name.
`ifndef CNC_ARC_LENGTH_UNIT_DEFINES_SVH
`define CNC_ARC_LENGTH_UNIT_DEFINES_SVH

// Check on every clock edge, reset included.
`define CAL_ASSERT_SYNC(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check outside reset only; rstn is active low.
`define CAL_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

### hdl/cal_pkg.sv
// Shared constants, types and the arctangent table of the arc length unit.
// Depends on nothing; all other files but the defines header use it.
`default_nettype none
package cal_pkg;

    localparam int TOL_W         = 16;
    localparam int LEN_W         = 35;
    localparam int ANG_FRAC      = 28;
    localparam int SQRT_STAGES   = 32;
    localparam int CORDIC_ITERS  = 24;
    localparam int CX_W          = 36;
    localparam int MQ_DEPTH      = 4;
    localparam int MQ_AW         = 2;
    localparam int OQ_DEPTH      = 2;
    localparam int OQ_AW         = 1;
    localparam int BACK_LAST     = 2 * SQRT_STAGES + CORDIC_ITERS + 10;

    localparam logic [28:0]      HALF_PI_Q = 29'd421657428;
    localparam logic [30:0]      TWO_PI_Q  = 31'd1686629712;
    localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [63:0]      LEN_RND   = 64'd1 << (ANG_FRAC - 1);

    typedef struct packed {
        logic               cmd;
        logic               ccw;
        logic               full;
        logic [31:0]        adx;
        logic [31:0]        ady;
        logic signed [31:0] oi;
        logic signed [31:0] oj;
        logic signed [33:0] cb;
        logic signed [33:0] cd;
        logic [31:0]        rmag;
        logic               rneg;
    } t_move;

    typedef struct packed {
        logic        cmd;
        logic        full;
        logic        long_arc;
        logic [31:0] adx;
        logic [31:0] ady;
        logic [31:0] rmag;
    } t_sa;

    typedef struct packed {
        logic        full;
        logic        long_arc;
        logic        too_small;
        logic        zero;
        logic [31:0] rad;
    } t_sb;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             full;
        logic             too_small;
    } t_res;

    function automatic logic [31:0] atan_q28(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd210828714;
            5'd1:  v = 32'd124459457;
            5'd2:  v = 32'd65760959;
            5'd3:  v = 32'd33381290;
            5'd4:  v = 32'd16755422;
            5'd5:  v = 32'd8385879;
            5'd6:  v = 32'd4193963;
            5'd7:  v = 32'd2097109;
            5'd8:  v = 32'd1048571;
            5'd9:  v = 32'd524287;
            5'd10: v = 32'd262144;
            5'd11: v = 32'd131072;
            5'd12: v = 32'd65536;
            5'd13: v = 32'd32768;
            5'd14: v = 32'd16384;
            5'd15: v = 32'd8192;
            5'd16: v = 32'd4096;
            5'd17: v = 32'd2048;
            5'd18: v = 32'd1024;
            5'd19: v = 32'd512;
            5'd20: v = 32'd256;
            5'd21: v = 32'd128;
            5'd22: v = 32'd64;
            5'd23: v = 32'd32;
            5'd24: v = 32'd16;
            5'd25: v = 32'd8;
            5'd26: v = 32'd4;
            5'd27: v = 32'd2;
            5'd28: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### hdl/cal_front.sv
// Front end: tolerance register, move classification and the move queue.
// Depends on cal_pkg.
`default_nettype none
module cal_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cal_pkg::TOL_W-1:0]  i_cfg_data,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic                       i_cmd,
    input  logic signed [31:0]         i_start_x,
    input  logic signed [31:0]         i_start_y,
    input  logic signed [31:0]         i_end_x,
    input  logic signed [31:0]         i_end_y,
    input  logic signed [31:0]         i_offset_i,
    input  logic signed [31:0]         i_offset_j,
    input  logic signed [31:0]         i_radius_signed,
    input  logic                       i_counterclockwise,
    input  logic                       i_pop,
    output logic                       o_avail,
    output cal_pkg::t_move             o_head
);
    import cal_pkg::*;

    logic [TOL_W-1:0]  r_tol;
    t_move             r_mq [MQ_DEPTH];
    logic [MQ_AW-1:0]  r_wp, r_rp;
    logic [MQ_AW:0]    r_cnt, n_cnt;
    logic signed [32:0] dx, dy, nr;
    logic              wr, rd;
    t_move             ent;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        dx = 33'(i_end_x) - 33'(i_start_x);
        dy = 33'(i_end_y) - 33'(i_start_y);
        nr = 33'sd0 - 33'(i_radius_signed);
        ent.cmd  = i_cmd;
        ent.ccw  = i_counterclockwise;
        ent.adx  = dx[32] ? 32'(33'sd0 - dx) : dx[31:0];
        ent.ady  = dy[32] ? 32'(33'sd0 - dy) : dy[31:0];
        ent.full = (ent.adx <= 32'(r_tol)) && (ent.ady <= 32'(r_tol));
        ent.oi   = i_offset_i;
        ent.oj   = i_offset_j;
        ent.cb   = 34'(dy) - 34'(i_offset_j);
        ent.cd   = 34'(dx) - 34'(i_offset_i);
        ent.rmag = i_radius_signed[31] ? nr[31:0] : i_radius_signed[31:0];
        ent.rneg = i_radius_signed[31];
    end

    assign o_full  = (r_cnt == (MQ_AW+1)'(MQ_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_head  = r_mq[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_avail;

    always_comb begin
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mq[r_wp] <= ent;
        end
    end

endmodule
`default_nettype wire

### hdl/cal_isqrt.sv
// Pipelined integer square root, one result bit per stage, stall by enable.
// Depends on cal_pkg.
`default_nettype none
module cal_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);
    import cal_pkg::*;

    logic [63:0] r_v [SQRT_STAGES];
    logic [63:0] r_r [SQRT_STAGES];

    for (genvar gk = 0; gk < SQRT_STAGES; gk++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gk);
        logic [63:0] v_in, r_in, trial;
        if (gk == 0) begin : g_first
            assign v_in = i_val;
            assign r_in = '0;
        end else begin : g_next
            assign v_in = r_v[gk-1];
            assign r_in = r_r[gk-1];
        end
        assign trial = r_in + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (v_in >= trial) begin
                    r_v[gk] <= v_in - trial;
                    r_r[gk] <= (r_in >> 1) + BIT;
                end else begin
                    r_v[gk] <= v_in;
                    r_r[gk] <= r_in >> 1;
                end
            end
        end
    end

    assign o_root = r_r[SQRT_STAGES-1][31:0];

endmodule
`default_nettype wire

### hdl/cal_back.sv
// Back end: radius, arc direction, chord geometry, CORDIC angle and length.
// Depends on cal_pkg and cal_isqrt.
`default_nettype none
module cal_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  cal_pkg::t_move i_head,
    output logic           o_pop,
    input  logic           i_oq_full,
    output logic           o_wr,
    output cal_pkg::t_res  o_res
);
    import cal_pkg::*;

    logic               en;
    logic [BACK_LAST:0] r_vld;

    t_move              r_s0, r_s1, r_s2;
    logic [63:0]        r_ai2, r_aj2, r_sq2, r_sq3;
    logic signed [50:0] r_pl, r_ql;
    logic signed [49:0] r_ph, r_qh;
    logic signed [67:0] r_p, r_q;
    t_sa                r_s3;
    t_sa                r_da [SQRT_STAGES];
    logic [30:0]        r_s4x, r_s4y, r_s4r;
    t_sb                r_sb4, r_sb5, r_sb6;
    logic [61:0]        r_s5x, r_s5y, r_s5r;
    logic [63:0]        r_c2, r_dd;
    t_sb                r_db [SQRT_STAGES];
    logic signed [CX_W-1:0] r_cx [CORDIC_ITERS+1];
    logic signed [CX_W-1:0] r_cy [CORDIC_ITERS+1];
    logic signed [31:0]     r_cz [CORDIC_ITERS+1];
    t_sb                    r_cs [CORDIC_ITERS+1];
    logic [30:0]        r_al;
    logic [31:0]        r_ar;
    logic               r_af, r_as, r_pf, r_ps;
    logic [62:0]        r_pr;
    t_res               r_res;

    logic signed [32:0] a1, c1;
    logic [31:0]        ai1, aj1, root_a, root_d, root_c, rad4;
    logic               sh4;
    logic [63:0]        c2_6, d2_6, dd6, sum_l;
    logic               brw6;
    logic [28:0]        half;
    logic [29:0]        two_h;
    logic [30:0]        alpha;
    logic [35:0]        q_l;
    t_sa                sa3;
    t_sb                sb4, sb6, sb_c;

    assign en    = !r_vld[BACK_LAST] || !i_oq_full;
    assign o_pop = en && i_avail;
    assign o_wr  = en && r_vld[BACK_LAST];
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[BACK_LAST-1:0], o_pop};
        end
    end

    always_comb begin
        a1  = 33'sd0 - 33'(r_s0.oi);
        c1  = 33'sd0 - 33'(r_s0.oj);
        ai1 = r_s0.oi[31] ? a1[31:0] : r_s0.oi[31:0];
        aj1 = r_s0.oj[31] ? c1[31:0] : r_s0.oj[31:0];

        sa3.cmd  = r_s2.cmd;
        sa3.full = r_s2.full;
        sa3.adx  = r_s2.adx;
        sa3.ady  = r_s2.ady;
        sa3.rmag = r_s2.rmag;
        if (r_s2.cmd) begin
            sa3.long_arc = r_s2.rneg;
        end else if (r_s2.ccw) begin
            sa3.long_arc = r_p < r_q;
        end else begin
            sa3.long_arc = r_p > r_q;
        end

        rad4 = r_da[SQRT_STAGES-1].cmd ? r_da[SQRT_STAGES-1].rmag : root_a;
        sh4  = r_da[SQRT_STAGES-1].adx[31] || r_da[SQRT_STAGES-1].ady[31] || rad4[31];
        sb4.full      = r_da[SQRT_STAGES-1].full;
        sb4.long_arc  = r_da[SQRT_STAGES-1].long_arc;
        sb4.too_small = 1'b0;
        sb4.zero      = 1'b0;
        sb4.rad       = rad4;

        c2_6 = 64'(r_s5x) + 64'(r_s5y);
        d2_6 = {r_s5r, 2'b00};
        {brw6, dd6} = {1'b0, d2_6} - {1'b0, c2_6};
        sb6 = r_sb5;
        sb6.too_small = brw6 && !r_sb5.full;

        sb_c = r_db[SQRT_STAGES-1];
        sb_c.zero = (root_d == '0) && (root_c == '0);

        if (r_cs[CORDIC_ITERS].too_small) begin
            half = HALF_PI_Q;
        end else if (r_cs[CORDIC_ITERS].zero || r_cz[CORDIC_ITERS][31]) begin
            half = '0;
        end else if (r_cz[CORDIC_ITERS] > $signed(32'(HALF_PI_Q))) begin
            half = HALF_PI_Q;
        end else begin
            half = r_cz[CORDIC_ITERS][28:0];
        end
        two_h = {half, 1'b0};
        if (r_cs[CORDIC_ITERS].full) begin
            alpha = TWO_PI_Q;
        end else if (r_cs[CORDIC_ITERS].long_arc) begin
            alpha = TWO_PI_Q - 31'(two_h);
        end else begin
            alpha = 31'(two_h);
        end

        sum_l = 64'(r_pr) + LEN_RND;
        q_l   = sum_l[63:ANG_FRAC];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0  <= i_head;
            r_s1  <= r_s0;
            r_ai2 <= 64'(ai1) * 64'(ai1);
            r_aj2 <= 64'(aj1) * 64'(aj1);
            r_pl  <= 51'(a1) * 51'($signed({1'b0, r_s0.cb[16:0]}));
            r_ph  <= 50'(a1) * 50'($signed(r_s0.cb[33:17]));
            r_ql  <= 51'(c1) * 51'($signed({1'b0, r_s0.cd[16:0]}));
            r_qh  <= 50'(c1) * 50'($signed(r_s0.cd[33:17]));
            r_s2  <= r_s1;
            r_sq2 <= r_ai2 + r_aj2;
            r_p   <= (68'(r_ph) <<< 17) + 68'(r_pl);
            r_q   <= (68'(r_qh) <<< 17) + 68'(r_ql);
            r_s3  <= sa3;
            r_sq3 <= r_sq2;
            r_da[0] <= r_s3;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                r_da[k] <= r_da[k-1];
            end
            r_s4x <= sh4 ? r_da[SQRT_STAGES-1].adx[31:1] : r_da[SQRT_STAGES-1].adx[30:0];
            r_s4y <= sh4 ? r_da[SQRT_STAGES-1].ady[31:1] : r_da[SQRT_STAGES-1].ady[30:0];
            r_s4r <= sh4 ? rad4[31:1] : rad4[30:0];
            r_sb4 <= sb4;
            r_s5x <= 62'(r_s4x) * 62'(r_s4x);
            r_s5y <= 62'(r_s4y) * 62'(r_s4y);
            r_s5r <= 62'(r_s4r) * 62'(r_s4r);
            r_sb5 <= r_sb4;
            r_c2  <= c2_6;
            r_dd  <= dd6;
            r_sb6 <= sb6;
            r_db[0] <= r_sb6;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                r_db[k] <= r_db[k-1];
            end
            r_cx[0] <= $signed({4'b0000, root_d});
            r_cy[0] <= $signed({4'b0000, root_c});
            r_cz[0] <= '0;
            r_cs[0] <= sb_c;
            r_al  <= alpha;
            r_ar  <= r_cs[CORDIC_ITERS].rad;
            r_af  <= r_cs[CORDIC_ITERS].full;
            r_as  <= r_cs[CORDIC_ITERS].too_small;
            r_pr  <= 63'(r_al) * 63'(r_ar);
            r_pf  <= r_af;
            r_ps  <= r_as;
            r_res.len       <= q_l[LEN_W] ? LEN_MAX : q_l[LEN_W-1:0];
            r_res.full      <= r_pf;
            r_res.too_small <= r_ps;
        end
    end

    for (genvar gi = 0; gi < CORDIC_ITERS; gi++) begin : g_cordic
        logic signed [CX_W-1:0] xs, ys;
        logic signed [31:0]     at;
        assign xs = r_cx[gi] >>> gi;
        assign ys = r_cy[gi] >>> gi;
        assign at = $signed(atan_q28(5'(gi)));
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_cy[gi][CX_W-1]) begin
                    r_cx[gi+1] <= r_cx[gi] + ys;
                    r_cy[gi+1] <= r_cy[gi] - xs;
                    r_cz[gi+1] <= r_cz[gi] + at;
                end else begin
                    r_cx[gi+1] <= r_cx[gi] - ys;
                    r_cy[gi+1] <= r_cy[gi] + xs;
                    r_cz[gi+1] <= r_cz[gi] - at;
                end
                r_cs[gi+1] <= r_cs[gi];
            end
        end
    end

    cal_isqrt u_sqrt_rad (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_sq3),
        .o_root (root_a)
    );

    cal_isqrt u_sqrt_height (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_dd),
        .o_root (root_d)
    );

    cal_isqrt u_sqrt_chord (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_c2),
        .o_root (root_c)
    );

endmodule
`default_nettype wire

### hdl/cal_outq.sv
// Two-entry result queue between the back end and the result ports.
// Depends on cal_pkg.
`default_nettype none
module cal_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  cal_pkg::t_res i_data,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output cal_pkg::t_res o_data
);
    import cal_pkg::*;

    t_res             r_q [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp, r_rp;
    logic [OQ_AW:0]   r_cnt, n_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == (OQ_AW+1)'(OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rp];
    assign wr      = i_wr && !o_full;
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

### hdl/cnc_arc_length_unit.sv
// Arc length unit: one move per cycle while the result queue has room; the
// back pipeline runs 32-stage square roots in two rounds and 24 CORDIC stages.
// The back pipeline holds as a whole while its output waits on a full queue.
// Synchronous active-low reset empties both queues and clears the tolerance
// register to zero; it takes effect at the next clock edge.
`default_nettype none
module cnc_arc_length_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [cal_pkg::TOL_W-1:0] i_cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_cmd,
    input  logic signed [31:0]        i_start_x,
    input  logic signed [31:0]        i_start_y,
    input  logic signed [31:0]        i_end_x,
    input  logic signed [31:0]        i_end_y,
    input  logic signed [31:0]        i_offset_i,
    input  logic signed [31:0]        i_offset_j,
    input  logic signed [31:0]        i_radius_signed,
    input  logic                      i_counterclockwise,
    output logic                      empty,
    input  logic                      pop,
    output logic [cal_pkg::LEN_W-1:0] o_arc_length,
    output logic                      o_full_circle,
    output logic                      o_radius_too_small
);
    import cal_pkg::*;

    logic  avail, mq_pop, oq_full, oq_wr;
    t_move head;
    t_res  res_in, res_out;

    cal_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_push             (push),
        .o_full             (full),
        .i_cmd              (i_cmd),
        .i_start_x          (i_start_x),
        .i_start_y          (i_start_y),
        .i_end_x            (i_end_x),
        .i_end_y            (i_end_y),
        .i_offset_i         (i_offset_i),
        .i_offset_j         (i_offset_j),
        .i_radius_signed    (i_radius_signed),
        .i_counterclockwise (i_counterclockwise),
        .i_pop              (mq_pop),
        .o_avail            (avail),
        .o_head             (head)
    );

    cal_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_avail   (avail),
        .i_head    (head),
        .o_pop     (mq_pop),
        .i_oq_full (oq_full),
        .o_wr      (oq_wr),
        .o_res     (res_in)
    );

    cal_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (oq_wr),
        .i_data  (res_in),
        .o_full  (oq_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (res_out)
    );

    assign o_arc_length       = res_out.len;
    assign o_full_circle      = res_out.full;
    assign o_radius_too_small = res_out.too_small;

endmodule
`default_nettype wire

### hdl/cal_chk.sv
// Port-level checker for the arc length unit, bound to the top level.
// Depends on cnc_arc_length_unit_defines.svh and cal_pkg.
`default_nettype none
`include "cnc_arc_length_unit_defines.svh"
module cal_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic [cal_pkg::LEN_W-1:0] o_arc_length,
    input logic                      o_full_circle,
    input logic                      o_radius_too_small
);
    `CAL_ASSERT_SYNC(a_rst_empty, i_clk, !i_rst_n |=> empty, "results left after reset")
    `CAL_ASSERT_SYNC(a_rst_room, i_clk, !i_rst_n |=> !full, "input blocked after reset")
    `CAL_ASSERT_RST(a_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_arc_length), "result beat changed while waiting")
    `CAL_ASSERT_RST(a_flags, i_clk, i_rst_n, !empty |-> !(o_full_circle && o_radius_too_small), "full circle flagged with clamped angle")
endmodule

bind cnc_arc_length_unit cal_chk u_chk (.*);
`default_nettype wire

### test/arc_length_checker.sv
`timescale 1ns / 100ps
// Watches the move and result queues of the arc length unit, predicts each length.
// Depends on cal_pkg for widths, the angle constants and the arctangent table.
module arc_length_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      cfg_beat,
    input  logic [cal_pkg::TOL_W-1:0] cfg_data,
    input  logic                      move_beat,
    input  logic                      cmd,
    input  logic signed [31:0]        start_x,
    input  logic signed [31:0]        start_y,
    input  logic signed [31:0]        end_x,
    input  logic signed [31:0]        end_y,
    input  logic signed [31:0]        offset_i,
    input  logic signed [31:0]        offset_j,
    input  logic signed [31:0]        radius_signed,
    input  logic                      ccw,
    input  logic                      result_beat,
    input  logic [cal_pkg::LEN_W-1:0] arc_length,
    input  logic                      full_circle,
    input  logic                      too_small,
    output int                        fail_count,
    output int                        pending
);
    import cal_pkg::*;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             full;
        logic             small_flag;
    } arc_t;

    arc_t        arcs_due[$];
    logic [15:0] tolerance;

    assign pending = arcs_due.size();

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] half_angle(input logic signed [63:0] x,
                                               input logic signed [63:0] y);
        logic signed [63:0] z;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        if (x == 0 && y == 0) return 0;
        z = 0;
        for (int k = 0; k < CORDIC_ITERS; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + $signed({32'd0, atan_q28(k[4:0])});
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - $signed({32'd0, atan_q28(k[4:0])});
            end
        end
        if (z < 0) z = 0;
        if (z > $signed({35'd0, HALF_PI_Q})) z = {35'd0, HALF_PI_Q};
        return z;
    endfunction

    function automatic int product_sign(input logic signed [63:0] a,
                                        input logic signed [63:0] b,
                                        input logic signed [63:0] c,
                                        input logic signed [63:0] d);
        logic signed [129:0] p;
        p = 130'(a) * 130'(b) - 130'(c) * 130'(d);
        return p > 0 ? 1 : (p < 0 ? -1 : 0);
    endfunction

    function automatic arc_t predict_arc();
        arc_t res;
        logic signed [63:0] dx, dy, oi, oj;
        logic [63:0] adx, ady, r, rr, c2, d2, half, alpha;
        logic [127:0] prod;
        logic longarc;
        int cs;
        dx = 64'(end_x) - 64'(start_x);
        dy = 64'(end_y) - 64'(start_y);
        oi = 64'(offset_i);
        oj = 64'(offset_j);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        res.small_flag = 0;
        if (cmd) begin
            r = radius_signed < 0 ? -64'(radius_signed) : 64'(radius_signed);
            longarc = radius_signed < 0;
        end else begin
            r = root64(oi * oi + oj * oj);
            cs = product_sign(-oi, dy - oj, -oj, dx - oi);
            longarc = ccw ? (cs < 0) : (cs > 0);
        end
        res.full = adx <= tolerance && ady <= tolerance;
        if (res.full) begin
            alpha = {33'd0, TWO_PI_Q};
        end else begin
            if (adx >= 64'h8000_0000 || ady >= 64'h8000_0000 || r >= 64'h8000_0000) begin
                adx = adx >> 1;
                ady = ady >> 1;
                rr = r >> 1;
            end else begin
                rr = r;
            end
            c2 = adx * adx + ady * ady;
            d2 = 4 * rr * rr;
            if (c2 > d2) begin
                res.small_flag = 1;
                half = {35'd0, HALF_PI_Q};
            end else begin
                half = half_angle(root64(d2 - c2), root64(c2));
            end
            alpha = 2 * half;
            if (longarc) alpha = {33'd0, TWO_PI_Q} - alpha;
        end
        prod = (128'(alpha) * 128'(r) + 128'(LEN_RND)) >> ANG_FRAC;
        res.len = prod > 128'(LEN_MAX) ? LEN_MAX : prod[LEN_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        arc_t want;
        if (!i_rst_n) begin
            tolerance <= 0;
            fail_count <= 0;
            arcs_due.delete();
        end else begin
            if (cfg_beat) tolerance <= cfg_data;
            if (move_beat) arcs_due.push_back(predict_arc());
            if (result_beat) begin
                if (arcs_due.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected beat: len %0d", arc_length);
                end else begin
                    want = arcs_due.pop_front();
                    if (want.len !== arc_length || want.full !== full_circle
                        || want.small_flag !== too_small) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("exp len %0d full %0b small %0b, got %0d %0b %0b",
                                     want.len, want.full, want.small_flag,
                                     arc_length, full_circle, too_small);
                    end
                end
            end
        end
    end
endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the arc length unit.
// Depends on cal_pkg, cnc_arc_length_unit and arc_length_checker.
module tb_top;
    import cal_pkg::*;

    logic i_clk, i_rst_n;
    logic i_cfg_valid, o_cfg_ready;
    logic [TOL_W-1:0] i_cfg_data;
    logic push, full, empty, pop;
    logic i_cmd, i_counterclockwise;
    logic signed [31:0] i_start_x, i_start_y, i_end_x, i_end_y;
    logic signed [31:0] i_offset_i, i_offset_j, i_radius_signed;
    logic [LEN_W-1:0] o_arc_length;
    logic o_full_circle, o_radius_too_small;
    int fail_count, pending;
    int quiet_cycles = 0;
    bit sink_calm, sink_hold;

    wire cfg_beat = i_cfg_valid && o_cfg_ready;
    wire move_beat = push && !full;
    wire result_beat = pop && !empty;

    cnc_arc_length_unit uut (.*);

    arc_length_checker chk (
        .i_clk, .i_rst_n, .cfg_beat, .cfg_data(i_cfg_data), .move_beat,
        .cmd(i_cmd), .start_x(i_start_x), .start_y(i_start_y),
        .end_x(i_end_x), .end_y(i_end_y), .offset_i(i_offset_i),
        .offset_j(i_offset_j), .radius_signed(i_radius_signed),
        .ccw(i_counterclockwise), .result_beat, .arc_length(o_arc_length),
        .full_circle(o_full_circle), .too_small(o_radius_too_small),
        .fail_count, .pending
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (move_beat || result_beat || cfg_beat) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("cnc_arc_length_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int gap;
        pop <= 0;
        @(posedge i_clk);
        while (1) begin
            if (sink_hold) begin
                pop <= 0;
                repeat (300) @(posedge i_clk);
                sink_hold = 0;
            end else if (!sink_calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 6);
                pop <= 0;
                repeat (gap) @(posedge i_clk);
            end else begin
                pop <= 1;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic signed [31:0] coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            default: return $signed($urandom_range(0, 32'h0FFF)) - 32'sh0800;
        endcase
    endfunction

    task automatic send_move(input logic cmd, input logic signed [31:0] sx, sy, ex, ey,
                             oi, oj, rs, input logic ccw);
        push <= 1;
        i_cmd <= cmd;
        i_start_x <= sx; i_start_y <= sy; i_end_x <= ex; i_end_y <= ey;
        i_offset_i <= oi; i_offset_j <= oj; i_radius_signed <= rs;
        i_counterclockwise <= ccw;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic idle_gap(input bit calm);
        if (!calm && $urandom_range(0, 5) == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic set_tolerance(input logic [15:0] t);
        i_cfg_valid <= 1;
        i_cfg_data <= t;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic random_moves(input int n, input bit calm);
        logic signed [31:0] sx, sy, ex, ey, cx, cy, r;
        int mode;
        repeat (n) begin
            mode = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
            sx = coord(mode); sy = coord(mode);
            cx = sx + coord(mode); cy = sy + coord(mode);
            r = $urandom_range(0, 3) == 0 ? coord(mode) : coord(mode) <<< 1;
            if ($urandom_range(0, 7) == 0) begin
                ex = sx + $signed($urandom_range(0, 15)) - 8;
                ey = sy + $signed($urandom_range(0, 15)) - 8;
            end else begin
                ex = cx + (cy - sy);
                ey = cy - (cx - sx) + coord(2);
                if ($urandom_range(0, 1)) begin ex = coord(mode); ey = coord(mode); end
            end
            send_move($urandom_range(0, 1), sx, sy, ex, ey, cx - sx, cy - sy, r,
                      $urandom_range(0, 1));
            idle_gap(calm);
        end
    endtask

    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    initial begin
        i_rst_n <= 0; i_cfg_valid <= 0; i_cfg_data <= 0; push <= 0;
        i_cmd <= 0; i_counterclockwise <= 0;
        i_start_x <= 0; i_start_y <= 0; i_end_x <= 0; i_end_y <= 0;
        i_offset_i <= 0; i_offset_j <= 0; i_radius_signed <= 0;
        sink_calm = 0; sink_hold = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_move(0, 0, 0, 0, 0, ONE, 0, 0, 0);
        send_move(0, ONE, 0, -ONE, 0, -ONE, 0, 0, 1);
        send_move(0, ONE, 0, 0, ONE, -ONE, 0, 0, 1);
        send_move(0, ONE, 0, 0, ONE, -ONE, 0, 0, 0);
        send_move(0, ONE, 0, 0, -ONE, -ONE, 0, 0, 1);
        send_move(1, 0, 0, 2 * ONE, 0, 0, 0, ONE, 0);
        send_move(1, 0, 0, ONE, ONE, 0, 0, -ONE, 1);
        send_move(1, 0, 0, 8 * ONE, 0, 0, 0, ONE, 1);
        send_move(1, 0, 0, ONE, 0, 0, 0, 0, 0);
        send_move(1, 0, 0, 0, 0, 0, 0, SMIN, 0);
        send_move(1, 0, 0, 3, 0, 0, 0, SMIN, 1);
        send_move(0, SMIN, SMIN, SMAX, SMAX, SMAX, SMAX, 0, 1);
        send_move(0, SMAX, SMIN, SMIN, SMAX, SMIN, SMIN, SMAX, 0);
        send_move(1, SMIN, 0, SMAX, 0, 0, 0, SMAX, 1);
        send_move(0, 0, 0, 0, 0, SMIN, SMIN, 0, 0);
        send_move(1, -1, -1, -1, -1, -1, -1, -1, 1);
        drain();

        set_tolerance(16'hFFFF);
        send_move(1, 0, 0, 32'sh0000_FFFF, -32'sh0000_FFFF, 0, 0, ONE, 0);
        send_move(1, 0, 0, 32'sh0001_0000, 0, 0, 0, ONE, 0);
        send_move(0, 5, 5, 5, 5, SMIN, SMAX, 0, 1);
        random_moves(60, 0);
        drain();

        set_tolerance(16'd8);
        sink_hold = 1;
        random_moves(140, 1);
        drain();

        set_tolerance(16'd0);
        random_moves(90, 0);
        drain();

        set_tolerance(16'd300);
        random_moves(100, 0);
        sink_calm = 1;
        random_moves(100, 1);
        drain();

        if (fail_count == 0) begin
            $display("cnc_arc_length_unit: match");
        end else begin
            $display("cnc_arc_length_unit: mismatch");
        end
        $finish;
    end
endmodule
